// File: hw/rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] minimum;
        logic               empty_res;
        logic [1:0]         status;
    } t_out;

endpackage

// File: hw/rtl/min_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap held in one single-port synchronous memory, one beat per item.
// ----------------------------------------------------------------------------
// Query: answered from the root shadow register. Insert: sift-up, reading each
//   parent and moving it down. Delete: linear search through the memory port,
//   then the last entry refills the slot and sifts down or up.
// Throughput: one item in flight; the single memory port sets the pace.
// Reset: synchronous, active low; empties the heap, memory contents kept.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SRCH    = 4'd1;
    localparam logic [3:0] S_DEL_RD  = 4'd2;
    localparam logic [3:0] S_DEL_LD  = 4'd3;
    localparam logic [3:0] S_RD_PAR  = 4'd4;
    localparam logic [3:0] S_CMP_PAR = 4'd5;
    localparam logic [3:0] S_DN_RDL  = 4'd6;
    localparam logic [3:0] S_DN_RDR  = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_RESP    = 4'd9;

    logic [31:0] mem [CAPACITY];

    logic [3:0]         r_state,     n_state;
    logic [CW-1:0]      r_count,     n_count;
    logic [AW-1:0]      r_k,         n_k;
    logic signed [31:0] r_val,       n_val;
    logic               r_up,        n_up;
    logic [CW-1:0]      r_scan,      n_scan;
    logic               r_pend,      n_pend;
    logic [AW-1:0]      r_paddr,     n_paddr;
    logic signed [31:0] r_lval,      n_lval;
    logic signed [31:0] r_min,       n_min;
    logic [1:0]         r_status,    n_status;
    t_out               r_out,       n_out;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_rdata;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    logic [AW-1:0]      w_par;
    logic [LW-1:0]      w_l;
    logic [LW-1:0]      w_r;
    logic [LW-1:0]      w_cnt;
    logic               w_rsel;
    logic signed [31:0] w_cval;
    logic [AW-1:0]      w_caddr;

    assign w_par   = (r_k - 1'b1) >> 1;
    assign w_l     = {1'b0, r_k, 1'b1};
    assign w_r     = w_l + 1'b1;
    assign w_cnt   = LW'(r_count);
    // right child wins only when present and strictly smaller
    assign w_rsel  = (w_r < w_cnt) && (r_rdata < r_lval);
    assign w_cval  = w_rsel ? r_rdata : r_lval;
    assign w_caddr = w_rsel ? w_r[AW-1:0] : w_l[AW-1:0];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_val       = r_val;
        n_up        = r_up;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_paddr     = r_paddr;
        n_lval      = r_lval;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_k;
        wr_data     = r_val;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_DONE;
                    n_val    = i_in_data.value;
                    case (i_in_data.mode)
                        MODE_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_k     = r_count[AW-1:0];
                                n_count = r_count + 1'b1;
                                n_up    = 1'b0;
                                n_state = S_RD_PAR;
                            end
                        end
                        MODE_DELETE: begin
                            n_scan  = '0;
                            n_pend  = 1'b0;
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // one read issued per cycle, compare the beat from the cycle before
                if (r_pend && (r_rdata == r_val)) begin
                    n_k     = r_paddr;
                    n_count = r_count - 1'b1;
                    n_pend  = 1'b0;
                    if ((LW'(r_paddr) + 1'b1) == w_cnt) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end else if (r_scan < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan[AW-1:0];
                    n_pend  = 1'b1;
                    n_paddr = r_scan[AW-1:0];
                    n_scan  = r_scan + 1'b1;
                end else begin
                    n_pend   = 1'b0;
                    n_status = ST_MISS;
                    n_state  = S_RESP;
                end
            end
            S_DEL_RD: begin
                // count already dropped, so it addresses the old last entry
                rd_en   = 1'b1;
                rd_addr = r_count[AW-1:0];
                n_state = S_DEL_LD;
            end
            S_DEL_LD: begin
                n_val   = r_rdata;
                n_up    = 1'b0;
                n_state = S_RD_PAR;
            end
            S_RD_PAR: begin
                if (r_k == '0) begin
                    if (r_up) begin
                        wr_en   = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DN_RDL;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = w_par;
                    n_state = S_CMP_PAR;
                end
            end
            S_CMP_PAR: begin
                if (r_val < r_rdata) begin
                    // move parent down, climb
                    wr_en   = 1'b1;
                    wr_data = r_rdata;
                    n_k     = w_par;
                    n_up    = 1'b1;
                    n_state = S_RD_PAR;
                end else if ((r_val > r_rdata) && !r_up) begin
                    n_state = S_DN_RDL;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_DN_RDL: begin
                if (w_l >= w_cnt) begin
                    wr_en   = 1'b1;
                    n_state = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = w_l[AW-1:0];
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_lval = r_rdata;
                if (w_r < w_cnt) begin
                    rd_en   = 1'b1;
                    rd_addr = w_r[AW-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (w_cval < r_val) begin
                    // move smaller child up, descend
                    wr_en   = 1'b1;
                    wr_data = w_cval;
                    n_k     = w_caddr;
                    n_state = S_DN_RDL;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.minimum     = (r_count == '0) ? '0 : r_min;
                    n_out.empty_res   = (r_count == '0);
                    n_out.status      = r_status;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // shadow of the root slot
        n_min = (wr_en && (wr_addr == '0)) ? wr_data : r_min;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_up        <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_up        <= n_up;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_k      <= n_k;
        r_val    <= n_val;
        r_scan   <= n_scan;
        r_paddr  <= n_paddr;
        r_lval   <= n_lval;
        r_min    <= n_min;
        r_status <= n_status;
        r_out    <= n_out;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(CAPACITY))
        else $error("heap count above capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (LW'(wr_addr) < w_cnt))
        else $error("write outside occupied slots");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == $past(r_count) + 1'b1) || (r_count + 1'b1 == $past(r_count))))
        else $error("count moved by more than one");

    a_scan_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SRCH) && r_pend) |-> (LW'(r_paddr) < w_cnt))
        else $error("search beat beyond last entry");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the min-heap priority queue.
// A heap kept alongside the block works out the minimum, empty flag and status
// of every accepted item; each result beat is compared field by field with the
// oldest pending report. Directed cases cover empty, extreme and duplicate
// values, a delete that climbs and a long output hold-off, then random traffic
// under both idling patterns and with no idling at all.
// ----------------------------------------------------------------------------
module tb
    import mhpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY         = 1024;
    localparam int          CLK_PERIOD       = 12;
    localparam int          RESET_CYCLES     = 9;
    localparam int          WATCHDOG_LIMIT   = 20000;
    localparam int          HOLD_CYCLES      = 400;
    localparam int          DRAIN_CYCLES     = 16;
    localparam int          RANDOM_PER_PHASE = 170;
    localparam logic [1:0]  MODE_SPARE       = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;

    int n_insert  = 0;
    int n_delete  = 0;
    int n_query   = 0;
    int n_full    = 0;
    int n_miss    = 0;
    int n_checked = 0;
    int peak_count = 0;

    // heap mirror: slots 0..pq_count-1 in heap order
    logic signed [31:0] pq_store [CAPACITY];
    int                 pq_count = 0;
    t_out               heap_reports [$];

    min_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Heap mirror
    // ------------------------------------------------------------------------
    function automatic void pq_swap(input int a, input int b);
        logic signed [31:0] t;
        t           = pq_store[a];
        pq_store[a] = pq_store[b];
        pq_store[b] = t;
    endfunction

    function automatic void pq_rise(input int k);
        int  up;
        bit  moving;
        moving = 1'b1;
        while (moving && k > 0 && k < pq_count) begin
            up = (k - 1) / 2;
            if (pq_store[k] < pq_store[up]) begin
                pq_swap(k, up);
                k = up;
            end else begin
                moving = 1'b0;
            end
        end
    endfunction

    function automatic void pq_sink(input int k);
        int child;
        bit moving;
        moving = 1'b1;
        while (moving && 2 * k + 1 < pq_count) begin
            child = 2 * k + 1;
            if (child + 1 < pq_count && pq_store[child + 1] < pq_store[child]) begin
                child++;
            end
            if (pq_store[child] < pq_store[k]) begin
                pq_swap(child, k);
                k = child;
            end else begin
                moving = 1'b0;
            end
        end
    endfunction

    // climb when smaller than (or equal to) the parent, otherwise sink
    function automatic void pq_settle(input int k);
        if (k == 0 || pq_store[k] > pq_store[(k - 1) / 2]) begin
            pq_sink(k);
        end else begin
            pq_rise(k);
        end
    endfunction

    function automatic int pq_find(input logic signed [31:0] v);
        for (int k = 0; k < pq_count; k++) begin
            if (pq_store[k] == v) return k;
        end
        return -1;
    endfunction

    function automatic t_out heap_apply(input t_in item);
        t_out res;
        int   k;
        res.status = ST_DONE;
        case (item.mode)
            MODE_INSERT: begin
                if (pq_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pq_store[pq_count] = item.value;
                    pq_count++;
                    pq_settle(pq_count - 1);
                end
            end
            MODE_DELETE: begin
                k = pq_find(item.value);
                if (k < 0) begin
                    res.status = ST_MISS;
                end else begin
                    pq_count--;
                    // removing the last slot needs no fix-up
                    if (k < pq_count) begin
                        pq_store[k] = pq_store[pq_count];
                        pq_settle(k);
                    end
                end
            end
            default: ;
        endcase
        res.minimum   = (pq_count > 0) ? pq_store[0] : 32'sd0;
        res.empty_res = (pq_count == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor: check the output beat, then record the accepted input beat
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : beat_check
        t_out want;
        t_out got;
        if (rst_n && out_valid && !out_stall) begin
            n_checked++;
            got = out_data;
            if (heap_reports.size() == 0) begin
                $error("result beat with no pending item: minimum %0d empty %0b status %0d",
                       got.minimum, got.empty_res, got.status);
                error_count++;
            end else begin
                want = heap_reports.pop_front();
                if (got.minimum !== want.minimum) begin
                    $error("minimum: expected %0d, got %0d", want.minimum, got.minimum);
                    error_count++;
                end
                if (got.empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            want = heap_apply(in_data);
            heap_reports.push_back(want);
            case (in_data.mode)
                MODE_INSERT: n_insert++;
                MODE_DELETE: n_delete++;
                default:     n_query++;
            endcase
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_MISS) n_miss++;
            if (pq_count > peak_count) peak_count = pq_count;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or a counted hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles without any beat on either side
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no beat for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, heap_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Entered and left at a falling edge; valid stays high for the next beat.
    task automatic send_item(input logic [1:0] mode, input logic signed [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        in_data.mode  = mode;
        in_data.value = value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom;
        // narrow pool: duplicates and repeated hits
        if (sel < 7) return $urandom_range(31) - 16;
        if (sel < 8) begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom_range(4095);
    endfunction

    function automatic t_in random_item();
        t_in item;
        int  sel;
        sel        = $urandom_range(99);
        item.value = random_value();
        if (sel < 50) begin
            item.mode = MODE_INSERT;
        end else if (sel < 80) begin
            item.mode = MODE_DELETE;
            // mostly delete something that is held
            if (pq_count > 0 && sel < 74) item.value = pq_store[$urandom_range(pq_count - 1)];
        end else if (sel < 92) begin
            item.mode = MODE_QUERY;
        end else begin
            item.mode = MODE_SPARE;
        end
        return item;
    endfunction

    task automatic test_empty_and_extremes();
        send_item(MODE_QUERY,  32'sd7);
        send_item(MODE_DELETE, 32'sd7);
        send_item(MODE_SPARE,  32'sd0);
        send_item(MODE_INSERT, 32'sh7fff_ffff);
        send_item(MODE_INSERT, 32'sh8000_0000);
        send_item(MODE_INSERT, 32'sd0);
        send_item(MODE_SPARE,  -32'sd1);
        send_item(MODE_DELETE, 32'sh8000_0000);
        send_item(MODE_DELETE, 32'sh7fff_ffff);
        send_item(MODE_DELETE, 32'sd0);
        send_item(MODE_QUERY,  -32'sd1);
    endtask

    task automatic test_duplicates();
        send_item(MODE_INSERT, 32'sd5);
        send_item(MODE_INSERT, 32'sd5);
        send_item(MODE_DELETE, 32'sd5);
        send_item(MODE_DELETE, 32'sd5);
        send_item(MODE_DELETE, 32'sd5);
    endtask

    // Heap 1,100,2,101,102,3,4: deleting 101 moves 4 into its slot, below 100.
    task automatic test_delete_climbs();
        send_item(MODE_INSERT, 32'sd1);
        send_item(MODE_INSERT, 32'sd100);
        send_item(MODE_INSERT, 32'sd2);
        send_item(MODE_INSERT, 32'sd101);
        send_item(MODE_INSERT, 32'sd102);
        send_item(MODE_INSERT, 32'sd3);
        send_item(MODE_INSERT, 32'sd4);
        send_item(MODE_DELETE, 32'sd101);
    endtask

    task automatic test_output_holdoff();
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) send_item(MODE_INSERT, random_value());
    endtask

    task automatic test_random_traffic(input int count);
        t_in item;
        for (int i = 0; i < count; i++) begin
            item = random_item();
            send_item(item.mode, item.value);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 88;
        test_empty_and_extremes();
        test_duplicates();
        test_delete_climbs();
        test_output_holdoff();
        test_random_traffic(RANDOM_PER_PHASE);

        send_idle_pct = 88;
        recv_idle_pct = 38;
        test_random_traffic(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_PER_PHASE);

        in_valid = 1'b0;
        wait (heap_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d deletes, %0d queries; %0d results checked",
                 n_insert, n_delete, n_query, n_checked);
        $display("Heap peaked at %0d of %0d entries; %0d inserts dropped, %0d deletes missed",
                 peak_count, CAPACITY, n_full, n_miss);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
